### hw/rtl/srch_pkg.sv
package srch_pkg;

    // Fixed field widths of the request, response and configuration items.
    localparam int IDX_W  = 5;
    localparam int WORD_W = 32;
    localparam int CFG_W  = 5;

    // Request commands.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_RANGE_FIRST = 1'b0;
    localparam logic CFG_RANGE_LAST  = 1'b1;

    // Order classification reported with each search.
    typedef enum logic [1:0] {
        ORD_UNSORTED = 2'd0,
        ORD_ASC      = 2'd1,
        ORD_DESC     = 2'd2,
        ORD_INVALID  = 2'd3
    } order_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PROBE,
        ST_COMPARE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         load_index;
        logic signed [WORD_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        order_t           order_status;
        logic             found;
        logic [IDX_W-1:0] found_index;
    } rsp_t;

endpackage

### hw/rtl/sorted_range_check_binary_search_core.sv
// Range order check and binary search over a store of signed 32-bit words.
//
// Requests arrive on req_valid/req_stall/req_data and are taken at a clock
// edge where req_valid is high and req_stall is low. A load request writes
// one word into the store and gives no response; a load to an index at or
// beyond DEPTH is dropped. A search request walks the configured range
// [range_first, range_last] through the store's single read port, one
// word per cycle, to classify its order (ending early once the range is
// known to be unsorted), then binary-searches the key, each probe a read
// and then a compare. One request is worked on at a time.
// Responses leave on rsp_valid/rsp_stall/rsp_data from an output register;
// the next request is taken while a response still waits, and a finished
// search waits only when the output register is still held by a stall.
// Range registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while the block is idle; the block does not enforce it.
// Reset returns the range to 0..31 and empties the output; the word store
// is not cleared and holds garbage until loaded.
module sorted_range_check_binary_search_core #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  srch_pkg::req_t                req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output srch_pkg::rsp_t                rsp_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [srch_pkg::CFG_W-1:0]    cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = srch_pkg::IDX_W;
    localparam int WW = srch_pkg::WORD_W;

    // Word store and its registered read port.
    logic signed [WW-1:0] mem [DEPTH];
    logic signed [WW-1:0] rd_data_reg;
    logic                 rd_en;
    logic [IW-1:0]        rd_idx;
    logic                 wr_en;

    // Configuration registers.
    logic [IW-1:0] range_first_reg;
    logic [IW-1:0] range_last_reg;

    // Sequencer state.
    srch_pkg::state_t     state_reg, state_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        lo_reg, lo_next;
    logic [IW-1:0]        hi_reg, hi_next;
    logic [IW-1:0]        mid_reg, mid_next;
    logic signed [WW-1:0] key_reg, key_next;
    logic signed [WW-1:0] prev_reg, prev_next;
    logic                 have_prev_reg, have_prev_next;
    logic                 not_asc_reg, not_asc_next;
    logic                 not_desc_reg, not_desc_next;
    srch_pkg::order_t     status_reg, status_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        index_reg, index_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    srch_pkg::rsp_t       rsp_reg, rsp_next;

    logic                 req_accept;
    logic                 range_bad;
    logic [IW:0]          mid_sum;
    logic                 go_right;

    assign req_stall  = (state_reg != srch_pkg::ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    assign range_bad = (range_last_reg < range_first_reg) ||
                       (32'(range_last_reg) >= 32'(DEPTH));
    assign wr_en = req_accept && (req_data.cmd == srch_pkg::CMD_LOAD) &&
                   (32'(req_data.load_index) < 32'(DEPTH));
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Memory write and synchronous read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(req_data.load_index)] <= req_data.data_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[AW'(rd_idx)];
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_first_reg <= '0;
            range_last_reg  <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srch_pkg::CFG_RANGE_FIRST: range_first_reg <= cfg_data;
                srch_pkg::CFG_RANGE_LAST:  range_last_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srch_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        not_asc_reg   <= not_asc_next;
        not_desc_reg  <= not_desc_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        index_reg     <= index_next;
        rsp_reg       <= rsp_next;
    end

    // Direction of the next probe; descending ranges mirror the compare.
    assign go_right = (key_reg > rd_data_reg) ^ (status_reg == srch_pkg::ORD_DESC);

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        not_asc_next   = not_asc_reg;
        not_desc_next  = not_desc_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        index_next     = index_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_en          = 1'b0;
        rd_idx         = cur_reg;

        unique case (state_reg)
            srch_pkg::ST_IDLE:
            begin
                if (req_accept && (req_data.cmd == srch_pkg::CMD_SEARCH))
                begin
                    key_next       = req_data.data_value;
                    found_next     = 1'b0;
                    index_next     = '0;
                    have_prev_next = 1'b0;
                    not_asc_next   = 1'b0;
                    not_desc_next  = 1'b0;
                    if (range_bad)
                    begin
                        status_next = srch_pkg::ORD_INVALID;
                        state_next  = srch_pkg::ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = range_first_reg;
                        cur_next   = range_first_reg;
                        state_next = srch_pkg::ST_CHECK;
                    end
                end
            end

            srch_pkg::ST_CHECK:
            begin
                // Compare each returned word with its left neighbor.
                not_asc_next   = not_asc_reg ||
                                 (have_prev_reg && !(prev_reg < rd_data_reg));
                not_desc_next  = not_desc_reg ||
                                 (have_prev_reg && !(prev_reg > rd_data_reg));
                prev_next      = rd_data_reg;
                have_prev_next = 1'b1;
                if (not_asc_next && not_desc_next)
                begin
                    status_next = srch_pkg::ORD_UNSORTED;
                    state_next  = srch_pkg::ST_DONE;
                end
                else if (cur_reg == range_last_reg)
                begin
                    status_next = not_asc_next ? srch_pkg::ORD_DESC : srch_pkg::ORD_ASC;
                    lo_next     = range_first_reg;
                    hi_next     = range_last_reg;
                    state_next  = srch_pkg::ST_PROBE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = cur_reg + 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
            end

            srch_pkg::ST_PROBE:
            begin
                // Read the middle word of the remaining interval.
                rd_en      = 1'b1;
                rd_idx     = mid_sum[IW:1];
                mid_next   = mid_sum[IW:1];
                state_next = srch_pkg::ST_COMPARE;
            end

            srch_pkg::ST_COMPARE:
            begin
                if (key_reg == rd_data_reg)
                begin
                    found_next = 1'b1;
                    index_next = mid_reg;
                    state_next = srch_pkg::ST_DONE;
                end
                else if (go_right)
                begin
                    if (mid_reg == hi_reg)
                    begin
                        state_next = srch_pkg::ST_DONE;
                    end
                    else
                    begin
                        lo_next    = mid_reg + 1'b1;
                        state_next = srch_pkg::ST_PROBE;
                    end
                end
                else
                begin
                    if (mid_reg == lo_reg)
                    begin
                        state_next = srch_pkg::ST_DONE;
                    end
                    else
                    begin
                        hi_next    = mid_reg - 1'b1;
                        state_next = srch_pkg::ST_PROBE;
                    end
                end
            end

            srch_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.order_status = status_reg;
                    rsp_next.found       = found_reg;
                    rsp_next.found_index = index_reg;
                    state_next           = srch_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srch_pkg::ST_IDLE;
            end
        endcase
    end

    // A hit is only reported for a sorted range.
    a_found_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.found |->
            (rsp_data.order_status == srch_pkg::ORD_ASC) ||
            (rsp_data.order_status == srch_pkg::ORD_DESC))
        else $error("found set on an unsorted or invalid range");

    // A miss always reports index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |-> (rsp_data.found_index == '0))
        else $error("nonzero index without a hit");

    // An invalid range goes straight to the result.
    a_invalid_done: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (req_data.cmd == srch_pkg::CMD_SEARCH) && range_bad |=>
            (state_reg == srch_pkg::ST_DONE) &&
            (status_reg == srch_pkg::ORD_INVALID))
        else $error("invalid range not reported at once");

    // Each probe stays inside the interval still being searched.
    a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srch_pkg::ST_COMPARE |->
            (mid_reg >= lo_reg) && (mid_reg <= hi_reg))
        else $error("probe outside the search interval");

    // The order walk never passes the end of the range.
    a_check_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srch_pkg::ST_CHECK |->
            (cur_reg <= range_last_reg) && (cur_reg >= range_first_reg))
        else $error("order walk outside the range");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_CYCLES = 64;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
    localparam srch_pkg::rsp_t NO_RSP = '{srch_pkg::ORD_UNSORTED, 1'b0, 5'd0};
    localparam srch_pkg::req_t NO_REQ = '{srch_pkg::CMD_LOAD, 5'd0, 32'sd0};

    typedef enum logic {ROW_RANGE, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        int             first;
        int             last;
        srch_pkg::req_t req;
        bit             typed;
        srch_pkg::rsp_t rsp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    srch_pkg::req_t req_data = NO_REQ;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    srch_pkg::rsp_t rsp_data;
    logic cfg_we = 1'b0;
    logic cfg_index = srch_pkg::CFG_RANGE_FIRST;
    logic [srch_pkg::CFG_W-1:0] cfg_data = '0;

    // Mirror of the block state used to work out search answers.
    logic signed [31:0] word_mirror [32];
    int range_lo = 0;
    int range_hi = 31;
    srch_pkg::rsp_t answer_q [$];
    srch_pkg::rsp_t want;

    int n_err = 0;
    int n_items = 0;
    int n_loads = 0;
    int n_searches = 0;
    int n_checked = 0;
    int n_ranges = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    // Directed rows: range settings and requests, with the answer typed in where obvious.
    dir_row_t dir_tab [23] = '{
        '{ROW_RANGE, 31, 0, NO_REQ, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, 32'sd0},
          1'b1, '{srch_pkg::ORD_INVALID, 1'b0, 5'd0}},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd0, WORD_MIN}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd1, WORD_MAX}, 1'b0, NO_RSP},
        '{ROW_RANGE, 0, 0, NO_REQ, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, WORD_MIN},
          1'b1, '{srch_pkg::ORD_ASC, 1'b1, 5'd0}},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, WORD_MAX},
          1'b1, '{srch_pkg::ORD_ASC, 1'b0, 5'd0}},
        '{ROW_RANGE, 0, 1, NO_REQ, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd31, WORD_MAX}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd1, WORD_MIN}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, WORD_MIN},
          1'b1, '{srch_pkg::ORD_UNSORTED, 1'b0, 5'd0}},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd0, WORD_MAX}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, WORD_MIN}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, 32'sd0}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd31, -32'sd1}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd30, 32'sd5}, 1'b0, NO_RSP},
        '{ROW_RANGE, 30, 31, NO_REQ, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, -32'sd1}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, 32'sd5}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd29, 32'sd7}, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_LOAD, 5'd29, 32'sd0}, 1'b0, NO_RSP},
        '{ROW_RANGE, 29, 31, NO_REQ, 1'b0, NO_RSP},
        '{ROW_REQ, 0, 0, '{srch_pkg::CMD_SEARCH, 5'd0, 32'sd5},
          1'b1, '{srch_pkg::ORD_UNSORTED, 1'b0, 5'd0}}
    };

    sorted_range_check_binary_search_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Order check of the configured range, then a binary search in the matching direction.
    function automatic srch_pkg::rsp_t search_answer(logic signed [31:0] key);
        srch_pkg::rsp_t r;
        bit rising;
        bit falling;
        bit go_up;
        int l;
        int h;
        int m;
        r = NO_RSP;
        rising = 1'b1;
        falling = 1'b1;
        if (range_hi < range_lo)
        begin
            r.order_status = srch_pkg::ORD_INVALID;
            return r;
        end
        for (int i = range_lo; i < range_hi; i++)
        begin
            if (word_mirror[i] >= word_mirror[i + 1]) rising = 1'b0;
            if (word_mirror[i] <= word_mirror[i + 1]) falling = 1'b0;
        end
        if (rising) r.order_status = srch_pkg::ORD_ASC;
        else if (falling) r.order_status = srch_pkg::ORD_DESC;
        else return r;
        l = range_lo;
        h = range_hi;
        while (l <= h)
        begin
            m = (l + h) / 2;
            if (key == word_mirror[m])
            begin
                r.found = 1'b1;
                r.found_index = m[4:0];
                return r;
            end
            go_up = falling ? (key < word_mirror[m]) : (key > word_mirror[m]);
            if (go_up) l = m + 1;
            else h = m - 1;
        end
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then update the mirror.
    task automatic send_req(input srch_pkg::req_t item, input bit typed,
                            input srch_pkg::rsp_t typed_rsp);
        req_valid <= 1'b1;
        req_data <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        n_items++;
        if (item.cmd == srch_pkg::CMD_LOAD)
        begin
            word_mirror[item.load_index] = item.data_value;
            n_loads++;
        end
        else
        begin
            answer_q.push_back(typed ? typed_rsp : search_answer(item.data_value));
            n_searches++;
        end
        // Bursts of back-to-back requests separated by random gaps.
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(0, 12);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_load(input int idx, input logic signed [31:0] value);
        srch_pkg::req_t item;
        item.cmd = srch_pkg::CMD_LOAD;
        item.load_index = idx[4:0];
        item.data_value = value;
        send_req(item, 1'b0, NO_RSP);
    endtask

    task automatic send_search(input logic signed [31:0] key);
        srch_pkg::req_t item;
        item.cmd = srch_pkg::CMD_SEARCH;
        item.load_index = 5'($urandom);
        item.data_value = key;
        send_req(item, 1'b0, NO_RSP);
    endtask

    // Both range registers are written only once the block has drained.
    task automatic set_range(input int first, input int last);
        req_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= srch_pkg::CFG_RANGE_FIRST;
        cfg_data <= first[srch_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= srch_pkg::CFG_RANGE_LAST;
        cfg_data <= last[srch_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        range_lo = first;
        range_hi = last;
        n_ranges++;
    endtask

    // One random phase: pick a range, fill it with shaped content, then search it.
    task automatic random_phase();
        int first;
        int last;
        int len;
        int shape;
        int pick;
        int k;
        int j;
        longint gmax;
        longint room;
        longint cur;
        logic signed [31:0] vals [32];
        logic signed [31:0] tmp;
        logic signed [31:0] key;
        if ($urandom_range(0, 11) == 0)
        begin
            first = $urandom_range(1, 31);
            last = $urandom_range(0, first - 1);
            set_range(first, last);
            repeat ($urandom_range(0, 3)) send_load($urandom_range(0, 31), $urandom);
            repeat ($urandom_range(1, 4)) send_search($urandom);
            return;
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) len = 32;
        else if (pick < 3) len = 1;
        else len = $urandom_range(2, 8);
        first = $urandom_range(0, 32 - len);
        pick = $urandom_range(0, 7);
        if (pick == 0) first = 0;
        else if (pick == 1) first = 32 - len;
        last = first + len - 1;
        set_range(first, last);

        // Strictly ascending words spread over the whole signed span, or packed tight.
        gmax = ($urandom_range(0, 3) == 0) ? 64'd3 : (64'h1_0000_0000 / len) - 2;
        room = 64'h1_0000_0000 - (len - 1) * (gmax + 1);
        pick = $urandom_range(0, 5);
        if (pick == 0) cur = 0;
        else if (pick == 1) cur = room - 1;
        else cur = longint'({32'd0, $urandom}) % room;
        cur = cur - 64'sd2147483648;
        for (k = 0; k < len; k++)
        begin
            vals[k] = cur[31:0];
            cur = cur + 1 + (longint'({32'd0, $urandom}) % (gmax + 1));
        end
        shape = $urandom_range(0, 9);
        if (shape >= 4 && shape <= 7)
        begin
            for (k = 0; k < len / 2; k++)
            begin
                tmp = vals[k];
                vals[k] = vals[len - 1 - k];
                vals[len - 1 - k] = tmp;
            end
        end
        else if (shape == 8)
        begin
            for (k = 0; k < len; k++) vals[k] = $urandom;
        end
        else if (shape == 9 && len > 1)
        begin
            j = $urandom_range(0, len - 2);
            vals[j + 1] = vals[j];
        end

        // Load every word of the range, with stray loads outside it mixed in.
        pick = $urandom_range(0, 1);
        for (k = 0; k < len; k++)
        begin
            j = pick ? k : len - 1 - k;
            if ($urandom_range(0, 5) == 0)
            begin
                tmp = $urandom;
                cur = $urandom_range(0, 31);
                if (cur < first || cur > last) send_load(int'(cur), tmp);
            end
            send_load(first + j, vals[j]);
        end

        repeat ((len == 32) ? $urandom_range(2, 5) : $urandom_range(3, 10))
        begin
            // Now and then a word inside the range is overwritten.
            if ($urandom_range(0, 7) == 0)
            begin
                j = $urandom_range(0, len - 1);
                vals[j] = ($urandom_range(0, 1) && len > 1) ? vals[(j + 1) % len] : $urandom;
                send_load(first + j, vals[j]);
            end
            pick = $urandom_range(0, 9);
            j = $urandom_range(0, len - 1);
            if (pick <= 4) key = vals[j];
            else if (pick == 5) key = vals[j] + 1;
            else if (pick == 6) key = vals[j] - 1;
            else if (pick == 7) key = $urandom;
            else if (pick == 8) key = WORD_MIN;
            else key = WORD_MAX;
            send_search(key);
        end
    endtask

    // Receiver stall pattern: quiet, light, heavy or periodic, switching now and then.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // Each taken response is compared with the oldest pending answer.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $error("response with none pending: order_status %0d found %0d index %0d",
                       rsp_data.order_status, rsp_data.found, rsp_data.found_index);
                n_err++;
            end
            else
            begin
                want = answer_q.pop_front();
                n_checked++;
                if (rsp_data.order_status !== want.order_status)
                begin
                    $error("order_status: expected %0d, got %0d",
                           want.order_status, rsp_data.order_status);
                    n_err++;
                end
                if (rsp_data.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                    n_err++;
                end
                if (rsp_data.found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, rsp_data.found_index);
                    n_err++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part walks the table.
        for (int r = 0; r < 23; r++)
        begin
            if (dir_tab[r].kind == ROW_RANGE) set_range(dir_tab[r].first, dir_tab[r].last);
            else send_req(dir_tab[r].req, dir_tab[r].typed, dir_tab[r].rsp);
        end

        while (n_items < RANDOM_ITEMS + 17) random_phase();

        // Drain outstanding answers and let the block settle.
        req_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d searches over %0d range settings.",
                 n_loads, n_searches, n_ranges);
        $display("Checked %0d responses, %0d mismatches.", n_checked, n_err);
        if (n_err == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
